[rtl/core/msk_pkg.sv]
// Shared constants and types of the segment key assigner.
`timescale 1ns / 1ps
`default_nettype none

package msk_pkg;

  localparam int FP_BYTES    = 6;
  localparam int QUEUE_DEPTH = 64;
  localparam int KEY_BYTES   = 4;
  localparam int BYTE_BITS   = 8;

  localparam int FP_W     = FP_BYTES * BYTE_BITS;
  localparam int SIZE_W   = 24;
  localparam int KEY_W    = KEY_BYTES * BYTE_BITS;
  localparam int TOTAL_W  = 32;
  localparam int PB_W     = 3;
  localparam int PAT_W    = 8;
  localparam int ADDR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W  = FP_W + SIZE_W;
  localparam int IN_W     = ((ENTRY_W + 7) / 8) * 8;
  localparam int OUTD_W   = FP_W + SIZE_W + KEY_W;
  localparam int OUT_W    = ((OUTD_W + 7) / 8) * 8;
  localparam int CIDX_W   = 3;
  localparam int CDATA_W  = 32;

  // register indexes of the configuration port
  localparam logic [CIDX_W-1:0] CFG_MIN_SIZE = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] CFG_MAX_SIZE = CIDX_W'(1);
  localparam logic [CIDX_W-1:0] CFG_PAT_BYTES = CIDX_W'(2);
  localparam logic [CIDX_W-1:0] CFG_PATTERN = CIDX_W'(3);

  // input word kinds (tuser)
  localparam logic OP_CHUNK = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [TOTAL_W-1:0] MIN_SIZE_RST = TOTAL_W'(524288);
  localparam logic [TOTAL_W-1:0] MAX_SIZE_RST = TOTAL_W'(2097152);
  localparam logic [PB_W-1:0]    PB_RST       = PB_W'(1);
  localparam logic [PAT_W-1:0]   PAT_RST      = PAT_W'(1);

  typedef logic [FP_W-1:0]    fp_t;
  typedef logic [SIZE_W-1:0]  size_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  // queue memory access from the controller
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

[rtl/core/msk_chunk_ram.sv]
// Chunk queue storage: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module msk_chunk_ram (
  input  wire logic              clk,
  input  wire msk_pkg::ram_req_t req,
  output msk_pkg::entry_t        rdata
);
  import msk_pkg::*;

  entry_t mem [QUEUE_DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/core/msk_seg_ctrl.sv]
// Segment controller: config registers, segment state, end test and drain sequencer.
`timescale 1ns / 1ps
`default_nettype none

module msk_seg_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [msk_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [msk_pkg::CDATA_W-1:0] cfg_data,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [msk_pkg::IN_W-1:0] in_tdata,
  input  wire logic                    in_tuser,
  output msk_pkg::ram_req_t            ram_req,
  input  wire msk_pkg::entry_t         ram_rdata,
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [msk_pkg::OUT_W-1:0]    out_tdata,
  output logic                         out_tlast
);
  import msk_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_DRD  = 2'd2;
  localparam logic [1:0] ST_DOUT = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [TOTAL_W-1:0] min_size_r, max_size_r;
  logic [PB_W-1:0]    pat_bytes_r;
  logic [PAT_W-1:0]   pattern_r;

  logic               op_r;
  fp_t                fp_r;
  size_t              size_r;

  logic [COUNT_W-1:0] count_r, count_nxt;
  fp_t                min_fp_r, min_fp_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [ADDR_W-1:0]  rd_ptr_r, rd_ptr_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]   out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;

  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] total_upd;
  logic               pat_hit;
  logic               seg_end;
  logic               drain_last;
  logic               out_free;
  logic [KEY_W-1:0]   key;
  int                 n_eff;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_size_r  <= MIN_SIZE_RST;
      max_size_r  <= MAX_SIZE_RST;
      pat_bytes_r <= PB_RST;
      pattern_r   <= PAT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MIN_SIZE:  min_size_r  <= cfg_data;
        CFG_MAX_SIZE:  max_size_r  <= cfg_data;
        CFG_PAT_BYTES: pat_bytes_r <= cfg_data[PB_W-1:0];
        CFG_PATTERN:   pattern_r   <= cfg_data[PAT_W-1:0];
        default: ;
      endcase
    end
  end

  // saturating segment total including the chunk being pushed
  assign sum       = {1'b0, total_r} + {{(TOTAL_W + 1 - SIZE_W){1'b0}}, size_r};
  assign total_upd = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];

  // leading bytes zero, then the byte at position n-1 matches the pattern
  always_comb begin
    n_eff = int'(pat_bytes_r);
    if (n_eff < 1) n_eff = 1;
    if (n_eff > FP_BYTES) n_eff = FP_BYTES;
    pat_hit = 1'b1;
    for (int i = 0; i < FP_BYTES; i++) begin
      if (i < n_eff - 1) begin
        if (fp_r[(FP_BYTES-1-i)*BYTE_BITS +: BYTE_BITS] != '0) pat_hit = 1'b0;
      end else if (i == n_eff - 1) begin
        if (fp_r[(FP_BYTES-1-i)*BYTE_BITS +: BYTE_BITS] != pattern_r) pat_hit = 1'b0;
      end
    end
  end

  always_comb begin
    if (total_upd < min_size_r)      seg_end = 1'b0;
    else if (total_upd > max_size_r) seg_end = 1'b1;
    else                             seg_end = pat_hit;
  end

  assign key        = min_fp_r[FP_W-1 -: KEY_W];
  assign drain_last = ({1'b0, rd_ptr_r} + COUNT_W'(1)) == count_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    min_fp_nxt    = min_fp_r;
    total_nxt     = total_r;
    rd_ptr_nxt    = rd_ptr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    ram_req.we    = 1'b0;
    ram_req.waddr = count_r[ADDR_W-1:0];
    ram_req.wdata = {size_r, fp_r};
    ram_req.raddr = rd_ptr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (op_r == OP_FLUSH) begin
          state_nxt = (count_r != '0) ? ST_DRD : ST_IDLE;
        end else begin
          ram_req.we = 1'b1;
          count_nxt  = count_r + COUNT_W'(1);
          total_nxt  = total_upd;
          if (fp_r < min_fp_r) min_fp_nxt = fp_r;
          if (seg_end || count_nxt == COUNT_W'(QUEUE_DEPTH)) state_nxt = ST_DRD;
          else state_nxt = ST_IDLE;
        end
      end
      ST_DRD: begin
        state_nxt = ST_DOUT;
      end
      ST_DOUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_W'({key, ram_rdata});
          out_last_nxt  = drain_last;
          if (drain_last) begin
            count_nxt  = '0;
            total_nxt  = '0;
            min_fp_nxt = '1;
            rd_ptr_nxt = '0;
            state_nxt  = ST_IDLE;
          end else begin
            rd_ptr_nxt = rd_ptr_r + ADDR_W'(1);
            state_nxt  = ST_DRD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      min_fp_r    <= '1;
      total_r     <= '0;
      rd_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      min_fp_r    <= min_fp_nxt;
      total_r     <= total_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r   <= in_tuser;
      fp_r   <= in_tdata[FP_W-1:0];
      size_r <= in_tdata[FP_W +: SIZE_W];
    end
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

[rtl/core/minhash_segment_key_assigner.sv]
// Top level of the MinHash segment key assigner.
`timescale 1ns / 1ps
`default_nettype none

// Chunk words are queued in a 64-entry memory while a saturating size total
// and the least fingerprint are kept; a pattern hit within the size window, a
// total above the maximum, a full queue or a flush word (tuser high) ends the
// segment, and the queue is replayed in order, each word carrying the top four
// bytes of the minimum fingerprint as key and tlast on the final one. A chunk
// word is taken while idle, then written to the queue and tested for an end;
// a drain reads each word from the registered queue memory, then loads it into
// the output register, waiting out any stall. Input is held off during a drain
// but is taken again while the last drained word still waits.
module minhash_segment_key_assigner (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [msk_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [msk_pkg::CDATA_W-1:0] cfg_data,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // chunk_fingerprint [47:0], chunk_size [71:48]
  input  wire logic [msk_pkg::IN_W-1:0]    in_tdata,
  // operation: 0 chunk, 1 flush
  input  wire logic                        in_tuser,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // out_fingerprint [47:0], out_size [71:48], segment_key [103:72]
  output logic [msk_pkg::OUT_W-1:0]        out_tdata,
  output logic                             out_tlast
);
  import msk_pkg::*;

  ram_req_t ram_req;
  entry_t   ram_rdata;

  msk_seg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  msk_chunk_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

[rtl/core/msk_checker.sv]
// Port-level checks of the segment key assigner, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module msk_checker (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_tvalid,
  input wire logic                     in_tready,
  input wire logic                     out_tvalid,
  input wire logic                     out_tready,
  input wire logic [msk_pkg::OUT_W-1:0] out_tdata,
  input wire logic                     out_tlast
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed under stall");

  // a taken word is processed before the next is taken
  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on consecutive cycles");

  // mid-segment drain holds the input off
  a_drain_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready during a drain");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not idle after reset");

endmodule

bind minhash_segment_key_assigner msk_checker u_msk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

[tb/sv/minhash_segment_key_checker.sv]
// Checker for the segment key assigner: tracks segments, predicts drained words, compares.
`timescale 1ns / 1ps

module minhash_segment_key_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  input  wire logic                        cfg_ready,
  input  wire logic [msk_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [msk_pkg::CDATA_W-1:0] cfg_data,
  input  wire logic                        in_tvalid,
  input  wire logic                        in_tready,
  input  wire logic [msk_pkg::IN_W-1:0]    in_tdata,
  input  wire logic                        in_tuser,
  input  wire logic                        out_tvalid,
  input  wire logic                        out_tready,
  input  wire logic [msk_pkg::OUT_W-1:0]   out_tdata,
  input  wire logic                        out_tlast,
  output int                               mismatch_count,
  output int                               pending_words,
  output int                               checked_words
);
  import msk_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    fp_t              fp;
    size_t            size;
    logic [KEY_W-1:0] key;
    logic             last;
  } drained_t;

  typedef struct packed {
    fp_t   fp;
    size_t size;
  } chunk_t;

  drained_t expected_drain[$];
  chunk_t   seg_chunks[$];
  fp_t      seg_min = '1;
  logic [TOTAL_W-1:0] seg_total = '0;

  logic [TOTAL_W-1:0] lo_size = MIN_SIZE_RST;
  logic [TOTAL_W-1:0] hi_size = MAX_SIZE_RST;
  logic [PB_W-1:0]    pat_len = PB_RST;
  logic [PAT_W-1:0]   pat_val = PAT_RST;

  int bad  = 0;
  int seen = 0;

  function automatic bit hits_boundary(fp_t fp);
    int n;
    if (seg_total < lo_size) return 1'b0;
    if (seg_total > hi_size) return 1'b1;
    n = (pat_len == 0) ? 1 : ((pat_len > FP_BYTES) ? FP_BYTES : int'(pat_len));
    // leading bytes must all be zero, byte n-1 carries the pattern
    for (int i = 0; i < n - 1; i++)
      if (fp[(FP_BYTES - 1 - i) * BYTE_BITS +: BYTE_BITS] != '0) return 1'b0;
    return fp[(FP_BYTES - n) * BYTE_BITS +: BYTE_BITS] == pat_val;
  endfunction

  task automatic release_segment();
    drained_t w;
    logic [KEY_W-1:0] key;
    key = seg_min[FP_W-1 -: KEY_W];
    foreach (seg_chunks[k]) begin
      w.fp   = seg_chunks[k].fp;
      w.size = seg_chunks[k].size;
      w.key  = key;
      w.last = (k == seg_chunks.size() - 1);
      expected_drain.push_back(w);
    end
    seg_chunks.delete();
    seg_min   = '1;
    seg_total = '0;
  endtask

  task automatic predict_segment(logic op, fp_t fp, size_t sz);
    chunk_t c;
    logic [TOTAL_W:0] sum;
    if (op == OP_FLUSH) begin
      // flush on an empty queue leaves everything alone
      if (seg_chunks.size() != 0) release_segment();
    end else begin
      c.fp   = fp;
      c.size = sz;
      if (seg_chunks.size() < QUEUE_DEPTH) seg_chunks.push_back(c);
      sum       = seg_total + sz;
      seg_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
      if (fp < seg_min) seg_min = fp;
      if (hits_boundary(fp) || seg_chunks.size() >= QUEUE_DEPTH) release_segment();
    end
  endtask

  always @(posedge clk) begin : track
    drained_t         want;
    fp_t              got_fp;
    size_t            got_size;
    logic [KEY_W-1:0] got_key;
    if (!rst_n) begin
      expected_drain.delete();
      seg_chunks.delete();
      seg_min   = '1;
      seg_total = '0;
      lo_size   = MIN_SIZE_RST;
      hi_size   = MAX_SIZE_RST;
      pat_len   = PB_RST;
      pat_val   = PAT_RST;
    end else begin
      if (out_tvalid && out_tready) begin
        got_fp   = out_tdata[FP_W-1:0];
        got_size = out_tdata[FP_W +: SIZE_W];
        got_key  = out_tdata[FP_W + SIZE_W +: KEY_W];
        if (expected_drain.size() == 0) begin
          bad++;
          if (bad <= REPORT_LIMIT)
            $display("unexpected drained word: fp %h size %h key %h last %b",
                     got_fp, got_size, got_key, out_tlast);
        end else begin
          want = expected_drain.pop_front();
          seen++;
          if (got_fp !== want.fp || got_size !== want.size || got_key !== want.key ||
              out_tlast !== want.last) begin
            bad++;
            if (bad <= REPORT_LIMIT)
              $display("drained word %0d (exp/got): fp %h/%h size %h/%h key %h/%h last %b/%b",
                       seen, want.fp, got_fp, want.size, got_size, want.key, got_key,
                       want.last, out_tlast);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN_SIZE:  lo_size = cfg_data;
          CFG_MAX_SIZE:  hi_size = cfg_data;
          CFG_PAT_BYTES: pat_len = cfg_data[PB_W-1:0];
          CFG_PATTERN:   pat_val = cfg_data[PAT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        predict_segment(in_tuser, in_tdata[FP_W-1:0], in_tdata[FP_W +: SIZE_W]);
    end
    pending_words  <= expected_drain.size();
    mismatch_count <= bad;
    checked_words  <= seen;
  end

endmodule

[tb/sv/minhash_segment_key_assigner_tb.sv]
// Testbench top for the segment key assigner: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module minhash_segment_key_assigner_tb;
  import msk_pkg::*;

  localparam logic [CIDX_W-1:0] CFG_UNMAPPED = CIDX_W'(5);
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int HOLD_CYCLES   = 400;
  localparam int STUCK_LIMIT   = 2000;

  logic               clk;
  logic               rst_n      = 1'b0;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [CIDX_W-1:0]  cfg_index  = '0;
  logic [CDATA_W-1:0] cfg_data   = '0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata   = '0;   // chunk_fingerprint [47:0], chunk_size [71:48]
  logic               in_tuser   = 1'b0; // operation
  logic               out_tvalid;
  logic               out_tready = 1'b1;
  logic [OUT_W-1:0]   out_tdata;         // out_fingerprint [47:0], out_size [71:48], key [103:72]
  logic               out_tlast;

  int mismatch_count;
  int pending_words;
  int checked_words;

  // stimulus-side view of the registers, used only to shape the traffic
  logic [31:0] cur_min = 32'(MIN_SIZE_RST);
  logic [2:0]  cur_pb  = PB_RST;
  logic [7:0]  cur_pat = PAT_RST;

  logic quiet         = 1'b0;
  logic pressure      = 1'b0;
  logic pressure_done = 1'b0;
  int   hold_left     = 0;
  int   stuck_cycles  = 0;
  int   words_sent    = 0;
  int   flushes_sent  = 0;
  int   settings      = 1;

  minhash_segment_key_assigner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  minhash_segment_key_checker key_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .pending_words  (pending_words),
    .checked_words  (checked_words)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: short random stalls, plus one long hold-off when pressure is raised
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
      hold_left  <= 0;
    end else if (pressure && !pressure_done) begin
      out_tready    <= 1'b0;
      hold_left     <= HOLD_CYCLES - 1;
      pressure_done <= 1'b1;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      hold_left  <= $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] lo, input logic [31:0] hi,
                            input logic [31:0] pb, input logic [31:0] pat);
    write_reg(CFG_MIN_SIZE, lo);
    write_reg(CFG_MAX_SIZE, hi);
    write_reg(CFG_PAT_BYTES, pb);
    write_reg(CFG_PATTERN, pat);
    cfg_valid <= 1'b0;
    cur_min  = lo;
    cur_pb   = pb[2:0];
    cur_pat  = pat[7:0];
    settings++;
  endtask

  task automatic send(input logic op, input fp_t fp, input size_t sz);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {sz, fp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    if (op == OP_FLUSH) flushes_sent++;
  endtask

  // block idle: nothing owed, and time for a chunk still being tested
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic fp_t next_fp(bit shaped);
    fp_t fp;
    int  n;
    fp = {16'($urandom), 32'($urandom)};
    if ($urandom_range(0, 9) == 0) fp[FP_W-1 -: 16] = '0;
    if (shaped && $urandom_range(0, 9) < 3) begin
      n = (cur_pb == 0) ? 1 : ((cur_pb > FP_BYTES) ? FP_BYTES : int'(cur_pb));
      for (int i = 0; i < n - 1; i++) fp[(FP_BYTES - 1 - i) * BYTE_BITS +: BYTE_BITS] = '0;
      fp[(FP_BYTES - n) * BYTE_BITS +: BYTE_BITS] = cur_pat;
    end
    return fp;
  endfunction

  // sizes scaled so a segment reaches the lower bound within a handful of chunks
  function automatic size_t pick_size();
    logic [31:0] span;
    span = ((cur_min >> 2) > 32'hFF_FFFF) ? 32'hFF_FFFF : (cur_min >> 2);
    if (span < 256) span = 32'hFFFF;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return size_t'($urandom);
      default: return size_t'($urandom_range(0, span));
    endcase
  endfunction

  initial begin
    logic [31:0] lo;
    logic [31:0] hi;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: window 512K..2M, one byte equal to 1
    send(OP_FLUSH, '1, '1);                        // empty queue, nothing out
    send(OP_CHUNK, 48'hFFFF_FFFF_FFFF, 24'h0);
    send(OP_CHUNK, 48'h0, 24'h0);
    send(OP_FLUSH, 48'h0, 24'h0);
    send(OP_CHUNK, 48'h0123_4567_89AB, 24'h08_0000); // total equals lower bound
    send(OP_CHUNK, 48'h0100_0000_0001, 24'h07_FFFF); // pattern hit below lower bound
    send(OP_CHUNK, 48'h8000_0000_0000, 24'hFF_FFFF); // above upper bound
    settle();

    // zero bounds, pattern width zero taken as one
    set_config(32'h0, 32'h0, 32'h0, 32'h0);
    send(OP_CHUNK, 48'h00AB_CDEF_0123, 24'h0);
    send(OP_CHUNK, 48'h5555_5555_5555, 24'h1);
    settle();

    // pattern width seven clamps to six
    set_config(32'h0, '1, 32'h7, 32'hFF);
    send(OP_CHUNK, 48'h0000_0000_00FF, 24'hFF_FFFF);
    send(OP_CHUNK, 48'h0000_0000_01FF, 24'h3);
    send(OP_CHUNK, 48'h0000_0000_00FE, 24'h3);
    send(OP_FLUSH, {16'($urandom), 32'($urandom)}, size_t'($urandom));
    settle();

    set_config(32'h0, '1, 32'h6, 32'h0);
    send(OP_CHUNK, 48'h0, 24'hFF_FFFF);
    settle();

    write_reg(CFG_UNMAPPED, '1);                   // must leave every register alone
    set_config(32'h0, '1, 32'h3, 32'h80);
    send(OP_CHUNK, 48'h0000_8012_3456, 24'h5);
    send(OP_CHUNK, 48'h0001_8000_0000, 24'h5);
    send(OP_FLUSH, 48'h0, 24'h0);
    settle();

    for (int p = 0; p < 4; p++) begin
      if (p == 1) begin
        // bounds out of reach: only a full queue or the closing flush ends a segment, under a long hold-off
        set_config('1, '1, 32'h6, 32'h5A);
        pressure <= 1'b1;
      end else begin
        lo = ($urandom_range(0, 2) == 0) ? 32'h0 : 32'($urandom_range(0, 32'h40_0000));
        case ($urandom_range(0, 3))
          0:       hi = lo;
          1:       hi = lo + 32'($urandom_range(0, 32'h100_0000));
          2:       hi = '1;
          default: hi = '0;
        endcase
        set_config(lo, hi, 32'($urandom_range(0, 7)), 32'($urandom_range(0, 255)));
      end
      if (p == 3) quiet <= 1'b1;
      for (int i = 0; i < ((p == 1) ? 66 : 58); i++) begin
        if (p != 1 && $urandom_range(0, 15) == 0)
          send(OP_FLUSH, {16'($urandom), 32'($urandom)}, size_t'($urandom));
        else
          send(OP_CHUNK, next_fp(p != 1), pick_size());
      end
      if (p == 1 || $urandom_range(0, 1) == 0)
        send(OP_FLUSH, {16'($urandom), 32'($urandom)}, size_t'($urandom));
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d input words (%0d flushes) over %0d register settings; %0d words drained",
             words_sent, flushes_sent, settings, checked_words);
    $display("Included a full-queue drain behind a %0d-cycle output hold-off", HOLD_CYCLES);
    if (mismatch_count == 0 && pending_words == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

[minhash_segment_key_assigner.f]
rtl/core/msk_pkg.sv
rtl/core/msk_chunk_ram.sv
rtl/core/msk_seg_ctrl.sv
rtl/core/minhash_segment_key_assigner.sv
rtl/core/msk_checker.sv
tb/sv/minhash_segment_key_checker.sv
tb/sv/minhash_segment_key_assigner_tb.sv
